>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers; each expects clk and rst_n in the calling scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/clnw_pkg.sv
// ----------------------------------------------------------------------------
// clnw_pkg
// Shared types, command codes, display byte constants and the init table of
// the character display nibble writer.
// ----------------------------------------------------------------------------
`default_nettype none

package clnw_pkg;

    // Defaults for the top-level parameters
    localparam int unsigned LINE_CHARS_DEF    = 16;
    localparam int unsigned POWER_WAIT_MS_DEF = 40;

    // Item commands
    typedef enum logic [1:0] {
        CMD_INIT   = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_CURSOR = 2'd2,
        CMD_CHAR   = 2'd3
    } cmd_t;

    // Event kinds and register select codes
    localparam logic EV_BUS   = 1'b0;
    localparam logic EV_POWER = 1'b1;
    localparam logic RS_CMD   = 1'b0;
    localparam logic RS_DATA  = 1'b1;

    // Display command bytes
    localparam logic [7:0] BYTE_CLEAR     = 8'h01;
    localparam logic [7:0] BYTE_LINE1_SET = 8'h80;
    localparam logic [7:0] BYTE_LINE2_SET = 8'hC0;

    // Index of the final event in the init sequence
    localparam logic [3:0] INIT_LAST_IDX = 4'd14;

    // Input word
    typedef struct packed {
        logic [1:0] command;
        logic [4:0] cursor_target;
        logic [7:0] char_code;
        logic [7:0] word_length;
        logic       word_first;
    } item_t;

    // Output word
    typedef struct packed {
        logic        event_kind;
        logic        reg_select;
        logic [3:0]  bus_nibble;
        logic [31:0] wait_after_ms;
        logic        last_event;
    } nib_t;

    // Source of the wait value attached to an event
    typedef enum logic [1:0] {
        WAIT_NONE  = 2'd0,
        WAIT_ONE   = 2'd1,
        WAIT_POWER = 2'd2
    } wait_sel_t;

    // One entry of the init sequence
    typedef struct packed {
        logic      kind;
        logic [3:0] nibble;
        wait_sel_t wsel;
    } init_evt_t;

    // Decoded work for one item: either the init sequence or up to three
    // bytes, of which the last may be character data
    typedef struct packed {
        logic            is_init;
        logic            last_char;
        logic [1:0]      nbytes;
        logic [2:0][7:0] code_bytes;
    } plan_t;

    // Init sequence: clear, power-on, 3, 3, 3, 2, 0x28, 0x0C, 0x06, clear
    function automatic init_evt_t init_event(input logic [3:0] idx);
        init_evt_t ev;
        ev = '{kind: EV_BUS, nibble: 4'h0, wsel: WAIT_NONE};
        case (idx)
            4'd0:  ev.nibble = 4'h0;
            4'd1:  ev.nibble = 4'h1;
            4'd2:  ev = '{kind: EV_POWER, nibble: 4'h0, wsel: WAIT_POWER};
            4'd3:  ev = '{kind: EV_BUS, nibble: 4'h3, wsel: WAIT_ONE};
            4'd4:  ev = '{kind: EV_BUS, nibble: 4'h3, wsel: WAIT_ONE};
            4'd5:  ev = '{kind: EV_BUS, nibble: 4'h3, wsel: WAIT_ONE};
            4'd6:  ev.nibble = 4'h2;
            4'd7:  ev.nibble = 4'h2;
            4'd8:  ev.nibble = 4'h8;
            4'd9:  ev.nibble = 4'h0;
            4'd10: ev.nibble = 4'hC;
            4'd11: ev.nibble = 4'h0;
            4'd12: ev.nibble = 4'h6;
            4'd13: ev.nibble = 4'h0;
            4'd14: ev.nibble = 4'h1;
            default: ev.nibble = 4'h0;
        endcase
        return ev;
    endfunction

endpackage

`default_nettype wire

>>> rtl/clnw_sequencer.sv
// ----------------------------------------------------------------------------
// clnw_sequencer
// Holds one decoded item and sends its nibble words out one per cycle while
// nib_stall is low, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module clnw_sequencer #(
    parameter int unsigned POWER_WAIT_MS = clnw_pkg::POWER_WAIT_MS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            plan_load,
    input  wire clnw_pkg::plan_t plan_in,
    output logic                 plan_free,
    input  wire logic [31:0]     char_wait,
    output logic                 nib_valid,
    input  wire logic            nib_stall,
    output clnw_pkg::nib_t       nib_data
);

    localparam logic [31:0] POWER_WAIT = 32'(POWER_WAIT_MS);

    logic              plan_valid_reg;
    clnw_pkg::plan_t   plan_reg;
    logic [3:0]        idx_reg;
    logic              out_valid_reg;
    clnw_pkg::nib_t    out_reg;

    logic              out_free;
    logic              emit_fire;
    logic [3:0]        last_idx;
    logic              is_last;
    logic [1:0]        byte_sel;
    logic [7:0]        cur_byte;
    clnw_pkg::init_evt_t init_ev;
    clnw_pkg::nib_t    ev;

    // Output stage frees when empty or when its word is taken
    assign out_free  = !out_valid_reg || !nib_stall;
    assign emit_fire = plan_valid_reg && out_free;
    assign last_idx  = plan_reg.is_init ? clnw_pkg::INIT_LAST_IDX
                                        : {1'b0, plan_reg.nbytes - 2'd1, 1'b1};
    assign is_last   = (idx_reg == last_idx);
    assign plan_free = !plan_valid_reg || (emit_fire && is_last);

    // Build the event at the current index
    assign byte_sel = idx_reg[2:1];
    assign init_ev  = clnw_pkg::init_event(idx_reg);

    always_comb
    begin
        case (byte_sel)
            2'd0:    cur_byte = plan_reg.code_bytes[0];
            2'd1:    cur_byte = plan_reg.code_bytes[1];
            default: cur_byte = plan_reg.code_bytes[2];
        endcase

        ev = '0;
        ev.last_event = is_last;
        if (plan_reg.is_init)
        begin
            ev.event_kind = init_ev.kind;
            ev.reg_select = clnw_pkg::RS_CMD;
            ev.bus_nibble = init_ev.nibble;
            case (init_ev.wsel)
                clnw_pkg::WAIT_ONE:   ev.wait_after_ms = 32'd1;
                clnw_pkg::WAIT_POWER: ev.wait_after_ms = POWER_WAIT;
                default:              ev.wait_after_ms = 32'd0;
            endcase
        end
        else
        begin
            ev.event_kind = clnw_pkg::EV_BUS;
            ev.reg_select = (plan_reg.last_char && (byte_sel == plan_reg.nbytes - 2'd1))
                            ? clnw_pkg::RS_DATA : clnw_pkg::RS_CMD;
            // High nibble first, low nibble second
            ev.bus_nibble = idx_reg[0] ? cur_byte[3:0] : cur_byte[7:4];
            ev.wait_after_ms = (ev.reg_select == clnw_pkg::RS_DATA && idx_reg[0])
                               ? char_wait : 32'd0;
        end
    end

    // Hold the plan and advance through its events
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plan_valid_reg <= 1'b0;
            idx_reg        <= 4'd0;
        end
        else if (plan_load)
        begin
            plan_valid_reg <= 1'b1;
            idx_reg        <= 4'd0;
        end
        else if (emit_fire && is_last)
        begin
            plan_valid_reg <= 1'b0;
        end
        else if (emit_fire)
        begin
            idx_reg <= idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (plan_load)
        begin
            plan_reg <= plan_in;
        end
    end

    // Output register: load a new word or drop the taken one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!nib_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_reg <= ev;
        end
    end

    assign nib_valid = out_valid_reg;
    assign nib_data  = out_reg;

    `ASSERT_IMPL(a_load_when_free, plan_load, plan_free, "plan loaded while busy")
    `ASSERT_IMPL(a_idx_in_range, plan_valid_reg, idx_reg <= last_idx, "event index overrun")
    `ASSERT_NEXT(a_plan_retires, emit_fire && is_last && !plan_load, !plan_valid_reg,
                 "plan not retired after last word")

endmodule

`default_nettype wire

>>> rtl/char_lcd_nibble_writer.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer: 2-line character display writer over a 4-bit bus
// A taken item is held in the plan register; its words pass the output register.
// An item gives 2 to 15 words, one per cycle while nib_stall is low; the next
// item is taken as the previous item's last word enters the output register.
// Reset clears cursor count, word index, split flag, wait register and valids.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module char_lcd_nibble_writer #(
    parameter int unsigned LINE_CHARS    = clnw_pkg::LINE_CHARS_DEF,
    parameter int unsigned POWER_WAIT_MS = clnw_pkg::POWER_WAIT_MS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    output logic                 item_stall,
    input  wire clnw_pkg::item_t item_data,
    output logic                 nib_valid,
    input  wire logic            nib_stall,
    output clnw_pkg::nib_t       nib_data,
    input  wire logic            cfg_we,
    input  wire logic [31:0]     cfg_wdata
);

    localparam logic [7:0] LC8   = 8'(LINE_CHARS);
    localparam logic [8:0] LC9   = 9'(LINE_CHARS);
    localparam logic [8:0] LC2_9 = 9'(2 * LINE_CHARS);

    logic [31:0]     char_wait_reg;
    logic [7:0]      cursor_reg, cursor_next;
    logic [7:0]      word_index_reg, word_index_next;
    logic            split_reg, split_next;

    logic            plan_free;
    logic            item_take;
    logic            char_take;
    clnw_pkg::plan_t plan_next;

    logic [8:0]      len9;
    logic [8:0]      span9;
    logic [7:0]      target8;
    logic [7:0]      target_byte;
    logic [1:0]      npre;
    logic [7:0]      pre0, pre1;

    assign item_stall = !plan_free;
    assign item_take  = item_valid && plan_free;
    assign char_take  = item_take && (item_data.command == clnw_pkg::CMD_CHAR);

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_wait_reg <= 32'd0;
        end
        else if (cfg_we)
        begin
            char_wait_reg <= cfg_wdata;
        end
    end

    // Cursor byte for a set cursor command
    assign target8     = {3'd0, item_data.cursor_target};
    assign target_byte = (target8 < LC8) ? (clnw_pkg::BYTE_LINE1_SET + target8)
                                         : (clnw_pkg::BYTE_LINE2_SET + target8 - LC8);

    // Placement of a word and the plan for the item
    assign len9  = (item_data.word_length == 8'd0) ? 9'd1 : {1'b0, item_data.word_length};
    assign span9 = {1'b0, cursor_reg} + len9;

    always_comb
    begin
        cursor_next     = cursor_reg;
        word_index_next = word_index_reg;
        split_next      = split_reg;
        npre            = 2'd0;
        pre0            = clnw_pkg::BYTE_LINE1_SET;
        pre1            = clnw_pkg::BYTE_CLEAR;
        plan_next       = '0;
        plan_next.nbytes = 2'd1;

        case (item_data.command)
            clnw_pkg::CMD_INIT:
            begin
                plan_next.is_init = 1'b1;
            end
            clnw_pkg::CMD_CLEAR:
            begin
                plan_next.code_bytes[0] = clnw_pkg::BYTE_CLEAR;
            end
            clnw_pkg::CMD_CURSOR:
            begin
                plan_next.code_bytes[0] = target_byte;
            end
            default:
            begin
                if (item_data.word_first)
                begin
                    word_index_next = 8'd0;
                    split_next      = 1'b0;
                    if (len9 > LC9)
                    begin
                        // Longer than a line: home, clear, split later
                        split_next  = 1'b1;
                        cursor_next = 8'd0;
                        npre        = 2'd2;
                    end
                    else if (span9 > LC2_9)
                    begin
                        // Runs past line two: home and clear
                        cursor_next = 8'd0;
                        npre        = 2'd2;
                    end
                    else if (span9 >= LC9 && cursor_reg < LC8)
                    begin
                        // Reaches or crosses end of line one: move to line two
                        cursor_next = LC8;
                        pre0        = clnw_pkg::BYTE_LINE2_SET;
                        npre        = 2'd1;
                    end
                end
                // Split word reaches the line boundary
                if (split_next && word_index_next == LC8)
                begin
                    pre0       = clnw_pkg::BYTE_LINE2_SET;
                    npre       = 2'd1;
                    split_next = 1'b0;
                end

                plan_next.last_char     = 1'b1;
                plan_next.nbytes        = npre + 2'd1;
                plan_next.code_bytes[0] = pre0;
                plan_next.code_bytes[1] = pre1;
                case (npre)
                    2'd0:    plan_next.code_bytes[0] = item_data.char_code;
                    2'd1:    plan_next.code_bytes[1] = item_data.char_code;
                    default: plan_next.code_bytes[2] = item_data.char_code;
                endcase

                cursor_next     = cursor_next + 8'd1;
                word_index_next = (word_index_next == 8'hFF) ? word_index_next
                                                             : word_index_next + 8'd1;
            end
        endcase
    end

    // Placement state advances on each character word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg     <= 8'd0;
            word_index_reg <= 8'd0;
            split_reg      <= 1'b0;
        end
        else if (char_take)
        begin
            cursor_reg     <= cursor_next;
            word_index_reg <= word_index_next;
            split_reg      <= split_next;
        end
    end

    clnw_sequencer #(
        .POWER_WAIT_MS (POWER_WAIT_MS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .plan_load (item_take),
        .plan_in   (plan_next),
        .plan_free (plan_free),
        .char_wait (char_wait_reg),
        .nib_valid (nib_valid),
        .nib_stall (nib_stall),
        .nib_data  (nib_data)
    );

    `ASSERT_NEXT(a_first_char_index, char_take && item_data.word_first,
                 word_index_reg == 8'd1, "word index not restarted")
    `ASSERT_NEXT(a_cursor_steps, char_take && !item_data.word_first && !split_reg,
                 cursor_reg == $past(cursor_reg) + 8'd1, "cursor did not advance")
    `ASSERT_NEXT(a_split_clears, char_take && !item_data.word_first && split_reg &&
                 word_index_reg == LC8, !split_reg, "split flag kept past line boundary")

endmodule

`default_nettype wire
